[sv/murmur3_32_hash_top_macros.svh]
// Assertion macros used by the hash engine port checker.
// Expects signals clk and rst in the scope of each use.
`ifndef MURMUR3_32_HASH_TOP_MACROS_SVH
`define MURMUR3_32_HASH_TOP_MACROS_SVH

// Checked outside reset only.
`define M3H_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define M3H_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/m3h_pkg.sv]
// Shared constants and types for the MurmurHash3 x86_32 engine.
// No dependencies.
`default_nettype none

package m3h_pkg;

  localparam logic [31:0] M3H_C1 = 32'hcc9e2d51;
  localparam logic [31:0] M3H_C2 = 32'h1b873593;
  localparam logic [31:0] M3H_N  = 32'he6546b64;
  localparam logic [31:0] M3H_F1 = 32'h85ebca6b;
  localparam logic [31:0] M3H_F2 = 32'hc2b2ae35;

  localparam int M3H_QUEUE_DEPTH = 4;

  localparam int M3H_ADDR_W = 3;
  localparam logic M3H_REG_SEED = 1'b0;

  // One scrambled word on its way from the front to the back.
  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  count;
    logic        full;
    logic        end_msg;
  } m3h_item_t;

endpackage

`default_nettype wire

[sv/m3h_front.sv]
// Front end: accepts input words, masks and classifies them, scrambles k1.
// Depends on m3h_pkg.
`default_nettype none

module m3h_front
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  byte_count,
  input  wire logic        last,
  output logic             push_valid,
  input  wire logic        push_ready,
  output m3h_item_t        push_item
);

  logic        s1_valid;
  logic [31:0] s1_prod;
  logic [2:0]  s1_count;
  logic        s1_full;
  logic        s1_end;
  logic        s2_valid;
  m3h_item_t   s2_item;

  logic        s1_ready;
  logic        s2_ready;
  logic [2:0]  count_sat;
  logic [31:0] mask;
  logic [31:0] s1_prod_next;
  logic [31:0] s1_rot;
  m3h_item_t   s2_item_next;

  always_comb begin
    count_sat = (byte_count > 3'd4) ? 3'd4 : byte_count;
    case (count_sat)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    s1_prod_next = 32'((data_word & mask) * M3H_C1);
  end

  always_comb begin
    s1_rot = {s1_prod[16:0], s1_prod[31:17]};
    s2_item_next.k       = 32'(s1_rot * M3H_C2);
    s2_item_next.count   = s1_count;
    s2_item_next.full    = s1_full;
    s2_item_next.end_msg = s1_end;
  end

  assign s2_ready = !s2_valid || push_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  assign push_valid = s2_valid;
  assign push_item  = s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_prod  <= s1_prod_next;
      s1_count <= count_sat;
      s1_full  <= (count_sat == 3'd4);
      // a short word closes the message even without the last flag
      s1_end   <= last || (count_sat != 3'd4);
    end
    if (s2_ready && s1_valid) begin
      s2_item <= s2_item_next;
    end
  end

endmodule

`default_nettype wire

[sv/m3h_queue.sv]
// Small FIFO that decouples the front end from the hash back end.
// Depends on m3h_pkg.
`default_nettype none

module m3h_queue
  import m3h_pkg::*;
#(
  parameter int DEPTH = M3H_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  m3h_item_t  wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output m3h_item_t  rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  m3h_item_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign wr_ready = (fill != CW'(DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = entries[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

[sv/m3h_back.sv]
// Back end: h1 recurrence, length count and the fmix32 finalizer pipeline.
// Depends on m3h_pkg.
`default_nettype none

module m3h_back
  import m3h_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] seed,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  m3h_item_t        pop_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      hash_value
);

  logic        busy;
  logic [31:0] acc;
  logic [31:0] len;
  logic        fin1_valid;
  logic [31:0] fin1;
  logic        fin2_valid;
  logic [31:0] fin2;

  logic        fin1_ready;
  logic        fin2_ready;
  logic        outreg_ready;
  logic        do_pop;
  logic [31:0] h_base;
  logic [31:0] len_base;
  logic [31:0] h_x;
  logic [31:0] h_rot;
  logic [31:0] h_after;
  logic [31:0] len_next;
  logic [31:0] fin1_shx;
  logic [31:0] fin2_next;
  logic [31:0] fin2_shx;
  logic [31:0] fin3_prod;
  logic [31:0] hash_next;

  assign outreg_ready = !out_valid || out_ready;
  assign fin2_ready   = !fin2_valid || outreg_ready;
  assign fin1_ready   = !fin1_valid || fin2_ready;
  // a closing transaction waits for room in the finalizer
  assign pop_ready    = !pop_item.end_msg || fin1_ready;
  assign do_pop       = pop_valid && pop_ready;

  always_comb begin
    h_base   = busy ? acc : seed;
    len_base = busy ? len : 32'd0;
    h_x      = h_base ^ pop_item.k;
    h_rot    = {h_x[18:0], h_x[31:19]};
    h_after  = pop_item.full ? ((h_rot << 2) + h_rot + M3H_N) : h_x;
    len_next = len_base + {29'd0, pop_item.count};
  end

  always_comb begin
    fin1_shx  = fin1 ^ (fin1 >> 16);
    fin2_next = 32'(fin1_shx * M3H_F1);
    fin2_shx  = fin2 ^ (fin2 >> 13);
    fin3_prod = 32'(fin2_shx * M3H_F2);
    hash_next = fin3_prod ^ (fin3_prod >> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      len        <= 32'd0;
      fin1_valid <= 1'b0;
      fin2_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_pop) begin
        busy <= !pop_item.end_msg;
        len  <= pop_item.end_msg ? 32'd0 : len_next;
      end
      if (fin1_ready) begin
        fin1_valid <= do_pop && pop_item.end_msg;
      end
      if (fin2_ready) begin
        fin2_valid <= fin1_valid;
      end
      if (outreg_ready) begin
        out_valid <= fin2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && !pop_item.end_msg) begin
      acc <= h_after;
    end
    if (do_pop && pop_item.end_msg) begin
      fin1 <= h_after ^ len_next;
    end
    if (fin2_ready && fin1_valid) begin
      fin2 <= fin2_next;
    end
    if (outreg_ready && fin2_valid) begin
      hash_value <= hash_next;
    end
  end

endmodule

`default_nettype wire

[sv/murmur3_32_hash_top.sv]
// Channel   Handshake              Payload
// in        in_valid / in_ready    data_word[31:0], byte_count[2:0], last
// out       out_valid / out_ready  hash_value[31:0]
// config    APB write/read         seed at byte address 0
//
// One word per cycle is taken in steady state unless the out side stalls; the
// h1 update is one shift-add per cycle in the back end. A closing word passes
// two scramble multiply stages, the queue, the h1 update and two fmix32
// multiply stages, one register each, before its hash is valid.
// Synchronous reset clears all valid state and the seed. Either side may
// stall; the queue absorbs the difference.
// Top level of the MurmurHash3 x86_32 engine; depends on m3h_pkg,
// m3h_front, m3h_queue and m3h_back.
`default_nettype none

module murmur3_32_hash_top
  import m3h_pkg::*;
#(
  parameter int QUEUE_DEPTH = M3H_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [31:0]           data_word,
  input  wire logic [2:0]            byte_count,
  input  wire logic                  last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                hash_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [M3H_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [31:0] seed;
  logic        seed_sel;
  logic        push_valid;
  logic        push_ready;
  m3h_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  m3h_item_t   pop_item;

  assign pready   = 1'b1;
  assign seed_sel = (paddr[M3H_ADDR_W-1:2] == M3H_REG_SEED);
  assign prdata   = seed_sel ? seed : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (psel && penable && pwrite && pready && seed_sel) begin
      seed <= pwdata;
    end
  end

  m3h_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  m3h_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  m3h_back u_back (
    .clk        (clk),
    .rst        (rst),
    .seed       (seed),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

`default_nettype wire

[sv/m3h_checker.sv]
// Port-level checks for murmur3_32_hash_top, attached by bind.
// Depends on m3h_pkg and murmur3_32_hash_top_macros.svh.
`default_nettype none
`include "murmur3_32_hash_top_macros.svh"

module m3h_port_props
  import m3h_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [31:0]           data_word,
  input wire logic [2:0]            byte_count,
  input wire logic                  last,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [31:0]           hash_value,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [M3H_ADDR_W-1:0] paddr,
  input wire logic [31:0]           pwdata,
  input wire logic [31:0]           prdata,
  input wire logic                  pready
);

  logic seed_hit;
  logic seed_wr;
  logic seed_rd;

  assign seed_hit = (paddr[M3H_ADDR_W-1:2] == M3H_REG_SEED);
  assign seed_wr  = psel && penable && pwrite && seed_hit;
  assign seed_rd  = psel && !pwrite && seed_hit;

  `M3H_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({data_word, byte_count, last}), "input not held")
  `M3H_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hash_value), "result not held")
  `M3H_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid, "result present right after reset")
  `M3H_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")
  `M3H_ASSERT(a_seed_readback, seed_wr ##1 seed_rd |-> prdata == $past(pwdata), "seed readback mismatch")

endmodule

bind murmur3_32_hash_top m3h_port_props u_m3h_port_props (.*);

`default_nettype wire
